/* rtl/bshm_pkg.sv */
// Shared constants, codes and helper functions for the bit-select hash map.
`timescale 1ns / 1ps
`default_nettype none
package bshm_pkg;

  localparam int DEF_WAYS           = 4;
  localparam int DEF_MAX_INDEX_BITS = 10;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;

  // Opcodes
  localparam logic [1:0] OP_FIND  = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  // Isolate the lowest set bit.
  function automatic logic [KEY_W-1:0] lsb_of(input logic [KEY_W-1:0] v);
    lsb_of = v & (~v + KEY_W'(1));
  endfunction

endpackage
`default_nettype wire

/* rtl/bshm_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module bshm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* rtl/bshm_extract.sv */
// Iterative bit-extract unit: peels one selected bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bshm_extract import bshm_pkg::*; #(
  parameter int MAX_INDEX_BITS = DEF_MAX_INDEX_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  input  wire logic [KEY_W-1:0]                      key,
  input  wire logic [KEY_W-1:0]                      sel,
  output logic                                       done,
  output logic [MAX_INDEX_BITS-1:0]                  idx,
  output logic [KEY_W-1:0]                           picked,
  output logic [$clog2(MAX_INDEX_BITS+1)-1:0]        n
);

  localparam int NW = $clog2(MAX_INDEX_BITS + 1);

  logic                      busy_r;
  logic [KEY_W-1:0]          rem_r;
  logic [KEY_W-1:0]          key_r;
  logic [MAX_INDEX_BITS-1:0] idx_r;
  logic [KEY_W-1:0]          pick_r;
  logic [NW-1:0]             n_r;
  logic                      finish;
  logic [KEY_W-1:0]          low;
  logic                      kbit;

  assign finish = (rem_r == '0) || (n_r == NW'(MAX_INDEX_BITS));
  assign low    = lsb_of(rem_r);
  assign kbit   = |(key_r & low);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && finish) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= sel;
      key_r  <= key;
      idx_r  <= '0;
      pick_r <= '0;
      n_r    <= '0;
    end else if (busy_r && !finish) begin
      rem_r  <= rem_r & ~low;
      pick_r <= pick_r | low;
      idx_r  <= idx_r | (MAX_INDEX_BITS'(kbit) << n_r);
      n_r    <= n_r + NW'(1);
    end
  end

  assign done   = busy_r && finish;
  assign idx    = idx_r;
  assign picked = pick_r;
  assign n      = n_r;

endmodule
`default_nettype wire

/* rtl/bit_select_hash_map_core.sv */
// Top level of the bit-select hash map: sequencer, table banks and rebuild stack.
//
//  channel | direction | handshake              | payload
//  in_     | input     | in_valid / in_ready    | in_opcode, in_key, in_value
//  out_    | output    | out_valid / out_ready  | out_found, out_result_value,
//          |           |                        | out_status, out_entry_total
//  cfg_    | input     | cfg_valid / cfg_ready  | cfg_data (initial_select)
//
// Find/add: the extract unit forms the bucket index (one bit a cycle), then each way is
//   read from the table RAM and checked in turn, and the result goes to the output.
// Expansion: per doubling, each old slot is read and then pushed, and each new slot is
//   cleared; then every stacked key is reinserted like an add. The table has a single
//   read port, so these steps run one after another.
// Reset and clear: the select mask is clipped through the extract unit, then a clearing
//   pass over WAYS * 2^popcount slots runs (WAYS slots after reset); no item is taken.
// A finished transaction waits in the output register; in_ready returns as soon as the
//   sequencer is idle, even while out_valid is held by out_ready low.
`timescale 1ns / 1ps
`default_nettype none
module bit_select_hash_map_core import bshm_pkg::*; #(
  parameter int WAYS           = DEF_WAYS,
  parameter int MAX_INDEX_BITS = DEF_MAX_INDEX_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              in_opcode,
  input  wire logic [KEY_W-1:0]        in_key,
  input  wire logic signed [VAL_W-1:0] in_value,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         out_found,
  output logic signed [VAL_W-1:0]      out_result_value,
  output logic [1:0]                   out_status,
  output logic [$clog2((1 << MAX_INDEX_BITS) * WAYS + 1)-1:0] out_entry_total,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [KEY_W-1:0]        cfg_data
);

  localparam int DEPTH = (1 << MAX_INDEX_BITS) * WAYS; // slots per bank
  localparam int AW    = $clog2(DEPTH);                // slot address
  localparam int TDEP  = 1 << (AW + 1);                // two banks
  localparam int CW    = $clog2(DEPTH + 1);            // stored count
  localparam int TW    = $clog2(DEPTH + 2);            // stack pointer
  localparam int SAW   = $clog2(DEPTH + 1);            // stack address
  localparam int LW    = $clog2(MAX_INDEX_BITS + 1);   // log2 of table length
  localparam int XW    = (WAYS > 1) ? $clog2(WAYS) : 1;

  // Sequencer states
  localparam logic [4:0] S_RST_X = 5'd0;   // start select clip
  localparam logic [4:0] S_CLR_XW = 5'd1;  // wait clip
  localparam logic [4:0] S_CLR   = 5'd2;   // clearing pass, committed bank
  localparam logic [4:0] S_IDLE  = 5'd3;
  localparam logic [4:0] S_LX    = 5'd4;   // lookup index start
  localparam logic [4:0] S_LXW   = 5'd5;
  localparam logic [4:0] S_LRD   = 5'd6;   // lookup way read
  localparam logic [4:0] S_LCK   = 5'd7;
  localparam logic [4:0] S_EXP   = 5'd8;   // expansion checks, push key
  localparam logic [4:0] S_ERD   = 5'd9;   // read old slot
  localparam logic [4:0] S_ECK   = 5'd10;  // push old slot
  localparam logic [4:0] S_ECLR  = 5'd11;  // clear work bank
  localparam logic [4:0] S_POP   = 5'd12;
  localparam logic [4:0] S_POPD  = 5'd13;
  localparam logic [4:0] S_PXW   = 5'd14;
  localparam logic [4:0] S_PRD   = 5'd15;
  localparam logic [4:0] S_PCK   = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  function automatic logic [AW:0] region(input logic [LW:0] lg);
    region = (AW + 1)'(WAYS) << lg;
  endfunction

  function automatic logic [AW-1:0] bucket_base(input logic [MAX_INDEX_BITS-1:0] ix,
                                                input logic [LW-1:0] lg);
    logic [MAX_INDEX_BITS:0] m;
    m = ((MAX_INDEX_BITS + 1)'(1) << lg) - (MAX_INDEX_BITS + 1)'(1);
    bucket_base = AW'(ix & m[MAX_INDEX_BITS-1:0]) * AW'(WAYS);
  endfunction

  logic [4:0]          state_r;
  logic                cur_r;      // committed bank
  logic [KEY_W-1:0]    init_sel_r;
  logic [KEY_W-1:0]    sel_r;
  logic [LW-1:0]       lg_r;
  logic [CW-1:0]       cnt_r;
  logic [1:0]          op_r;
  logic [KEY_W-1:0]    key_r;
  logic [VAL_W-1:0]    val_r;
  logic [KEY_W-1:0]    k_r;        // key being placed during rebuild
  logic [VAL_W-1:0]    v_r;
  logic [KEY_W-1:0]    wsel_r;     // working mask, length, count
  logic [LW-1:0]       wlg_r;
  logic [CW-1:0]       wcnt_r;
  logic [TW-1:0]       top_r;
  logic                src_w_r;    // expansion reads the work bank
  logic [KEY_W-1:0]    fk_r;       // first key of the full bucket
  logic [KEY_W-1:0]    nb_r;       // new select bit
  logic [AW-1:0]       base_r;
  logic [XW-1:0]       x_r;
  logic [AW:0]         z_r;
  logic [AW:0]         end_r;
  logic                clr_resp_r;
  logic                found_r;
  logic [VAL_W-1:0]    resv_r;
  logic [1:0]          stat_r;
  logic                out_valid_r;
  logic                out_found_r;
  logic [VAL_W-1:0]    out_val_r;
  logic [1:0]          out_stat_r;
  logic [CW-1:0]       out_cnt_r;

  // Extract unit
  logic                      x_start;
  logic [KEY_W-1:0]          x_key;
  logic [KEY_W-1:0]          x_sel;
  logic                      x_done;
  logic [MAX_INDEX_BITS-1:0] x_idx;
  logic [KEY_W-1:0]          x_pick;
  logic [LW-1:0]             x_n;

  // Table and stack ports
  logic             tk_we, tv_we;
  logic [AW:0]      t_waddr, t_raddr;
  logic [KEY_W-1:0] tk_wdata, tk_rdata;
  logic [VAL_W-1:0] tv_wdata, tv_rdata;
  logic             s_we;
  logic [SAW-1:0]   s_waddr, s_raddr;
  logic [KEY_W-1:0] sk_rdata;
  logic [VAL_W-1:0] sv_rdata;

  logic [AW-1:0]    way_addr;
  logic [AW:0]      z_dec;
  logic [TW-1:0]    top_dec;
  logic [KEY_W-1:0] nb_cand;
  logic             last_way;

  assign way_addr = base_r + AW'(x_r);
  assign z_dec    = z_r - (AW + 1)'(1);
  assign top_dec  = top_r - TW'(1);
  assign nb_cand  = lsb_of((fk_r ^ k_r) & ~wsel_r);
  assign last_way = (x_r == XW'(WAYS - 1));

  assign x_start = (state_r == S_RST_X) || (state_r == S_LX) || (state_r == S_POPD);
  assign x_key   = (state_r == S_POPD) ? sk_rdata : key_r;
  assign x_sel   = (state_r == S_RST_X) ? init_sel_r :
                   (state_r == S_POPD)  ? wsel_r : sel_r;

  bshm_extract #(.MAX_INDEX_BITS(MAX_INDEX_BITS)) u_extract (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (x_start),
    .key    (x_key),
    .sel    (x_sel),
    .done   (x_done),
    .idx    (x_idx),
    .picked (x_pick),
    .n      (x_n)
  );

  // Memory port steering
  always_comb begin
    tk_we    = 1'b0;
    tv_we    = 1'b0;
    t_waddr  = {cur_r, way_addr};
    tk_wdata = key_r;
    tv_wdata = val_r;
    t_raddr  = {cur_r, way_addr};
    s_we     = 1'b0;
    s_waddr  = top_r[SAW-1:0];
    s_raddr  = top_dec[SAW-1:0];
    case (state_r)
      S_CLR: begin
        tk_we    = 1'b1;
        t_waddr  = {cur_r, z_r[AW-1:0]};
        tk_wdata = '0;
      end
      S_LCK: begin
        if (op_r == OP_ADD && (tk_rdata == key_r || tk_rdata == '0)) begin
          tk_we = 1'b1;
          tv_we = 1'b1;
        end
      end
      S_EXP: begin
        s_we = 1'b1;
      end
      S_ERD: begin
        t_raddr = {src_w_r ? !cur_r : cur_r, z_dec[AW-1:0]};
      end
      S_ECK: begin
        s_we = (tk_rdata != '0) && (top_r <= TW'(DEPTH));
      end
      S_ECLR: begin
        tk_we    = 1'b1;
        t_waddr  = {!cur_r, z_r[AW-1:0]};
        tk_wdata = '0;
      end
      S_PRD: begin
        t_raddr = {!cur_r, way_addr};
      end
      S_PCK: begin
        t_waddr  = {!cur_r, way_addr};
        tk_wdata = k_r;
        tv_wdata = v_r;
        if (tk_rdata == '0 || tk_rdata == k_r) begin
          tk_we = 1'b1;
          tv_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Stack write data: the pending key in S_EXP, an old slot in S_ECK
  logic [KEY_W-1:0] s_wkey;
  logic [VAL_W-1:0] s_wval;
  assign s_wkey = (state_r == S_EXP) ? k_r : tk_rdata;
  assign s_wval = (state_r == S_EXP) ? v_r : tv_rdata;

  bshm_ram #(.WIDTH(KEY_W), .DEPTH(TDEP)) u_tab_key (
    .clk(clk), .we(tk_we), .waddr(t_waddr), .wdata(tk_wdata),
    .raddr(t_raddr), .rdata(tk_rdata)
  );

  bshm_ram #(.WIDTH(VAL_W), .DEPTH(TDEP)) u_tab_val (
    .clk(clk), .we(tv_we), .waddr(t_waddr), .wdata(tv_wdata),
    .raddr(t_raddr), .rdata(tv_rdata)
  );

  bshm_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH + 1)) u_stk_key (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wkey),
    .raddr(s_raddr), .rdata(sk_rdata)
  );

  bshm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH + 1)) u_stk_val (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wval),
    .raddr(s_raddr), .rdata(sv_rdata)
  );

  // Configuration register, taken at any time
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_sel_r <= '0;
    end else if (cfg_valid) begin
      init_sel_r <= cfg_data;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RST_X;
      cur_r       <= 1'b0;
      sel_r       <= '0;
      lg_r        <= '0;
      wlg_r       <= '0;
      cnt_r       <= '0;
      top_r       <= '0;
      clr_resp_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // S_DONE loads the output register itself
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_RST_X: begin
          state_r <= S_CLR_XW;
        end
        S_CLR_XW: begin
          if (x_done) begin
            sel_r   <= x_pick;
            lg_r    <= x_n;
            cnt_r   <= '0;
            z_r     <= '0;
            end_r   <= region({1'b0, x_n});
            state_r <= S_CLR;
          end
        end
        S_CLR: begin
          z_r <= z_r + (AW + 1)'(1);
          if (z_r + (AW + 1)'(1) == end_r) begin
            state_r <= clr_resp_r ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= in_opcode;
            key_r   <= in_key;
            val_r   <= in_value;
            found_r <= 1'b0;
            resv_r  <= '1;
            stat_r  <= ST_OK;
            if (in_opcode == OP_CLEAR) begin
              clr_resp_r <= 1'b1;
              state_r    <= S_RST_X;
            end else if (in_opcode == OP_FIND || in_opcode == OP_ADD) begin
              if (in_key == '0) begin
                stat_r  <= ST_ZERO;
                state_r <= S_DONE;
              end else begin
                state_r <= S_LX;
              end
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_LX: begin
          state_r <= S_LXW;
        end
        S_LXW: begin
          if (x_done) begin
            base_r  <= bucket_base(x_idx, lg_r);
            x_r     <= '0;
            state_r <= S_LRD;
          end
        end
        S_LRD: begin
          state_r <= S_LCK;
        end
        S_LCK: begin
          if (tk_rdata == key_r) begin
            found_r <= 1'b1;
            if (op_r == OP_FIND) begin
              resv_r <= tv_rdata;
            end
            state_r <= S_DONE;
          end else if (tk_rdata == '0) begin
            if (op_r == OP_ADD) begin
              cnt_r <= cnt_r + CW'(1);
            end
            state_r <= S_DONE;
          end else begin
            if (x_r == '0) begin
              fk_r <= tk_rdata;
            end
            if (!last_way) begin
              x_r     <= x_r + XW'(1);
              state_r <= S_LRD;
            end else if (op_r == OP_FIND) begin
              state_r <= S_DONE;
            end else begin
              // bucket full: rebuild from the committed bank
              k_r     <= key_r;
              v_r     <= val_r;
              wsel_r  <= sel_r;
              wlg_r   <= lg_r;
              wcnt_r  <= cnt_r;
              top_r   <= '0;
              src_w_r <= 1'b0;
              if (x_r == '0) begin
                fk_r <= tk_rdata;
              end
              state_r <= S_EXP;
            end
          end
        end
        S_EXP: begin
          if (wlg_r == LW'(MAX_INDEX_BITS) || nb_cand == '0 || top_r > TW'(DEPTH)) begin
            stat_r  <= ST_FULL;
            state_r <= S_DONE;
          end else begin
            top_r   <= top_r + TW'(1);
            nb_r    <= nb_cand;
            z_r     <= region({1'b0, wlg_r});
            state_r <= S_ERD;
          end
        end
        S_ERD: begin
          if (z_r == '0) begin
            end_r   <= region({1'b0, wlg_r} + (LW + 1)'(1));
            state_r <= S_ECLR;
          end else begin
            state_r <= S_ECK;
          end
        end
        S_ECK: begin
          if (tk_rdata != '0 && top_r <= TW'(DEPTH)) begin
            top_r <= top_r + TW'(1);
          end
          z_r     <= z_dec;
          state_r <= S_ERD;
        end
        S_ECLR: begin
          z_r <= z_r + (AW + 1)'(1);
          if (z_r + (AW + 1)'(1) == end_r) begin
            wsel_r  <= wsel_r | nb_r;
            wlg_r   <= wlg_r + LW'(1);
            wcnt_r  <= '0;
            src_w_r <= 1'b1;
            state_r <= S_POP;
          end
        end
        S_POP: begin
          if (top_r == '0) begin
            // rebuild finished: the work bank becomes the table
            cur_r   <= !cur_r;
            sel_r   <= wsel_r;
            lg_r    <= wlg_r;
            cnt_r   <= wcnt_r;
            state_r <= S_DONE;
          end else begin
            top_r   <= top_dec;
            state_r <= S_POPD;
          end
        end
        S_POPD: begin
          k_r     <= sk_rdata;
          v_r     <= sv_rdata;
          state_r <= S_PXW;
        end
        S_PXW: begin
          if (x_done) begin
            base_r  <= bucket_base(x_idx, wlg_r);
            x_r     <= '0;
            state_r <= S_PRD;
          end
        end
        S_PRD: begin
          state_r <= S_PCK;
        end
        S_PCK: begin
          if (tk_rdata == '0) begin
            wcnt_r  <= wcnt_r + CW'(1);
            state_r <= S_POP;
          end else if (tk_rdata == k_r) begin
            state_r <= S_POP;
          end else begin
            if (x_r == '0) begin
              fk_r <= tk_rdata;
            end
            if (last_way) begin
              state_r <= S_EXP;
            end else begin
              x_r     <= x_r + XW'(1);
              state_r <= S_PRD;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_found_r <= found_r;
            out_val_r   <= resv_r;
            out_stat_r  <= stat_r;
            out_cnt_r   <= cnt_r;
            clr_resp_r  <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_result_value = out_val_r;
  assign out_status       = out_stat_r;
  assign out_entry_total  = out_cnt_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("stored count beyond capacity");

  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= TW'(DEPTH + 1))
    else $error("rebuild stack overflow");

  a_lg_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lg_r <= LW'(MAX_INDEX_BITS) && wlg_r <= LW'(MAX_INDEX_BITS))
    else $error("table length beyond limit");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && (!out_valid_r || out_ready) |=> out_valid && in_ready)
    else $error("finished transaction not delivered");

endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for bit_select_hash_map_core: directed and random map traffic.
`timescale 1ns / 1ps
`default_nettype none
module testbench import bshm_pkg::*;;

  localparam int WAYS      = DEF_WAYS;
  localparam int IDX_BITS  = DEF_MAX_INDEX_BITS;
  localparam int MAX_LEN   = 1 << IDX_BITS;
  localparam int DEPTH     = MAX_LEN * WAYS;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int DRAIN_CYC = 200;      // settle time after the last transaction
  localparam int CYCLE_CAP = 3000000;  // run guard
  localparam logic [1:0] OP_NOP = 2'd3;  // unused opcode, answered as a no-op

  // Clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  // DUT ports
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_opcode = OP_FIND;
  logic [KEY_W-1:0]        in_key = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    out_found;
  logic signed [VAL_W-1:0] out_result_value;
  logic [1:0]              out_status;
  logic [CNT_W-1:0]        out_entry_total;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [KEY_W-1:0]        cfg_data = '0;

  bit_select_hash_map_core #(
    .WAYS(WAYS),
    .MAX_INDEX_BITS(IDX_BITS)
  ) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_opcode), .in_key(in_key), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_found(out_found), .out_result_value(out_result_value),
    .out_status(out_status), .out_entry_total(out_entry_total),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // One expected response
  typedef struct {
    logic                    found;
    logic signed [VAL_W-1:0] value;
    logic [1:0]              status;
    logic [CNT_W-1:0]        total;
  } answer_t;

  answer_t pending_answers[$];
  int      err_count = 0;
  int      cycle_count = 0;

  // Shadow map state
  logic [KEY_W-1:0] map_key [DEPTH];
  logic [VAL_W-1:0] map_val [DEPTH];
  logic [KEY_W-1:0] map_mask;
  int unsigned      map_len;
  int unsigned      map_count;
  logic [KEY_W-1:0] shadow_init_sel;

  // Scratch for the rebuild
  logic [KEY_W-1:0] wrk_key [DEPTH];
  logic [VAL_W-1:0] wrk_val [DEPTH];
  logic [KEY_W-1:0] stk_key [DEPTH + 1];
  logic [VAL_W-1:0] stk_val [DEPTH + 1];

  // Traffic shaping knobs
  bit sender_steady;   // no gaps on the input side
  bit sink_steady;     // no stalls on the result side

  // Pack the key bits picked by sel toward bit 0.
  function automatic int unsigned bucket_bits(logic [KEY_W-1:0] k, logic [KEY_W-1:0] sel);
    int unsigned r;
    int j;
    r = 0;
    j = 0;
    for (int i = 0; i < KEY_W; i++) begin
      if (sel[i]) begin
        if (k[i]) r |= (1 << j);
        j++;
      end
    end
    return r;
  endfunction

  // Table reset: keep the lowest IDX_BITS select bits.
  function automatic void wipe_map();
    int n;
    n = 0;
    map_mask = '0;
    for (int i = 0; i < KEY_W; i++) begin
      if (shadow_init_sel[i] && n < IDX_BITS) begin
        map_mask[i] = 1'b1;
        n++;
      end
    end
    map_len = 1 << n;
    map_count = 0;
    for (int i = 0; i < DEPTH; i++) map_key[i] = '0;
  endfunction

  // Insert with table doubling; returns 1 when refused for capacity.
  function automatic bit grow_and_insert(logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
    logic [KEY_W-1:0] sel, k, nb;
    logic [VAL_W-1:0] v;
    int unsigned len, cnt, base, x, top;
    sel = map_mask;
    len = map_len;
    cnt = map_count;
    wrk_key = map_key;
    wrk_val = map_val;
    stk_key[0] = key;
    stk_val[0] = val;
    top = 1;
    while (top > 0) begin
      top--;
      k = stk_key[top];
      v = stk_val[top];
      base = (bucket_bits(k, sel) & (len - 1) & (MAX_LEN - 1)) * WAYS;
      for (x = 0; x < WAYS && wrk_key[base + x] != 0; x++)
        if (wrk_key[base + x] == k) break;
      if (x < WAYS) begin
        if (wrk_key[base + x] == 0) cnt++;
        wrk_key[base + x] = k;
        wrk_val[base + x] = v;
      end else begin
        if (len >= MAX_LEN) return 1'b1;
        nb = (wrk_key[base] ^ k) & ~sel;
        nb = nb & (~nb + 1);
        if (nb == 0) return 1'b1;
        if (top > DEPTH) return 1'b1;
        stk_key[top] = k;
        stk_val[top] = v;
        top++;
        // re-stack the old table in reverse so it reinserts in table order
        for (int z = len * WAYS; z > 0; z--) begin
          if (wrk_key[z - 1] != 0 && top <= DEPTH) begin
            stk_key[top] = wrk_key[z - 1];
            stk_val[top] = wrk_val[z - 1];
            top++;
          end
        end
        for (int i = 0; i < DEPTH; i++) wrk_key[i] = '0;
        sel |= nb;
        len *= 2;
        cnt = 0;
      end
    end
    map_key = wrk_key;
    map_val = wrk_val;
    map_mask = sel;
    map_len = len;
    map_count = cnt;
    return 1'b0;
  endfunction

  // Apply one operation to the shadow map and return its answer.
  function automatic answer_t apply_map_op(logic [1:0] op, logic [KEY_W-1:0] key,
                                           logic [VAL_W-1:0] val);
    answer_t a;
    int unsigned base, x;
    a.found = 1'b0;
    a.value = -1;
    a.status = ST_OK;
    if (op == OP_CLEAR) begin
      wipe_map();
    end else if ((op == OP_FIND || op == OP_ADD) && key == 0) begin
      a.status = ST_ZERO;
    end else if (op == OP_FIND || op == OP_ADD) begin
      base = (bucket_bits(key, map_mask) & (map_len - 1) & (MAX_LEN - 1)) * WAYS;
      for (x = 0; x < WAYS && map_key[base + x] != 0; x++)
        if (map_key[base + x] == key) break;
      if (x < WAYS && map_key[base + x] == key) begin
        a.found = 1'b1;
        if (op == OP_FIND) a.value = map_val[base + x];
        else map_val[base + x] = val;
      end else if (op == OP_ADD) begin
        if (x < WAYS) begin
          map_key[base + x] = key;
          map_val[base + x] = val;
          map_count++;
        end else if (grow_and_insert(key, val)) begin
          a.status = ST_FULL;
        end
      end
    end
    a.total = map_count[CNT_W-1:0];
    return a;
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one transaction; valid stays high across back-to-back sends.
  task automatic send_op(logic [1:0] op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_key    <= key;
    in_value  <= val;
    do @(posedge clk); while (!in_ready);
    pending_answers.push_back(apply_map_op(op, key, val));
  endtask

  // Hold off until every response is back, then let the block finish internal work.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // Write initial_select while idle; the live table is untouched until a clear.
  task automatic write_init_select(logic [KEY_W-1:0] sel);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= sel;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_init_sel = sel;
  endtask

  // Result sink with random backpressure
  int stall_left = 0;
  always @(posedge clk) begin
    if (sink_steady) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(99) < 30) stall_left <= pick_gap();
    end
  end

  // Response checker
  always @(posedge clk) begin
    answer_t exp_a;
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected response: found=%0d value=%0d status=%0d total=%0d",
               out_found, out_result_value, out_status, out_entry_total);
        err_count++;
      end else begin
        exp_a = pending_answers.pop_front();
        if (out_found !== exp_a.found) begin
          $error("found: expected %0d, got %0d", exp_a.found, out_found);
          err_count++;
        end
        if (out_result_value !== exp_a.value) begin
          $error("result_value: expected %0d, got %0d", exp_a.value, out_result_value);
          err_count++;
        end
        if (out_status !== exp_a.status) begin
          $error("status: expected %0d, got %0d", exp_a.status, out_status);
          err_count++;
        end
        if (out_entry_total !== exp_a.total) begin
          $error("entry_total: expected %0d, got %0d", exp_a.total, out_entry_total);
          err_count++;
        end
      end
    end
  end

  // Run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Basic find/add/update, key zero, unused opcode, a first expansion, clear.
  task automatic test_basic_ops();
    send_op(OP_FIND, 32'h1, 32'h0);
    send_op(OP_ADD, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_op(OP_ADD, 32'h1, 32'h8000_0000);
    send_op(OP_FIND, 32'hFFFF_FFFF, 32'h0);
    send_op(OP_FIND, 32'h1, 32'h0);
    send_op(OP_ADD, 32'h1, 32'h0);           // update in place
    send_op(OP_FIND, 32'h1, 32'h0);
    send_op(OP_FIND, 32'h0, 32'h0);          // key zero rejected
    send_op(OP_ADD, 32'h0, 32'h1234);
    send_op(OP_NOP, 32'h55, 32'h66);
    send_op(OP_ADD, 32'h2, 32'h22);          // single bucket fills up ...
    send_op(OP_ADD, 32'h4, 32'h44);
    send_op(OP_ADD, 32'h8, 32'h88);          // ... and this one forces a rebuild
    send_op(OP_ADD, 32'h10, 32'hFFFF_FFFF);
    send_op(OP_FIND, 32'h8, 32'h0);
    send_op(OP_FIND, 32'h2, 32'h0);
    send_op(OP_CLEAR, 32'h0, 32'h0);
    send_op(OP_FIND, 32'h1, 32'h0);
  endtask

  // Clipped select at full width: a full bucket cannot grow, so the add is refused.
  task automatic test_capacity_refusal();
    write_init_select(32'hFFFF_FFFF);
    send_op(OP_CLEAR, 32'h0, 32'h0);
    for (int i = 1; i <= WAYS + 1; i++)
      send_op(OP_ADD, (i << IDX_BITS) | 32'h155, i);
    send_op(OP_FIND, ((WAYS + 1) << IDX_BITS) | 32'h155, 32'h0);
    send_op(OP_FIND, (1 << IDX_BITS) | 32'h155, 32'h0);
    write_init_select(32'h0);
    send_op(OP_CLEAR, 32'h0, 32'h0);
  endtask

  // Random phases: each picks a select mask, clears, then works a small key pool.
  task automatic test_random_traffic(int n_items);
    logic [KEY_W-1:0] pool [32];
    logic [KEY_W-1:0] sel, k;
    int sent, phase, r, bits;
    sent = 0;
    phase = 0;
    while (sent < n_items) begin
      r = $urandom_range(9);
      if (phase == 1) sel = $urandom();         // wide mask, gets clipped
      else if (r < 2) sel = '0;
      else begin
        sel = '0;
        bits = $urandom_range(1, 3);
        repeat (bits) sel[$urandom_range(KEY_W - 1)] = 1'b1;
      end
      write_init_select(sel);
      sender_steady = ($urandom_range(3) == 0);
      sink_steady   = ($urandom_range(3) == 0);
      send_op(OP_CLEAR, $urandom(), $urandom());
      sent++;
      foreach (pool[i]) begin
        pool[i] = $urandom();
        if (pool[i] == 0) pool[i] = 32'h1;
      end
      for (int j = 0; j < 100 && sent < n_items; j++) begin
        k = pool[$urandom_range(31)];
        r = $urandom_range(99);
        if (r < 45) send_op(OP_ADD, k, $urandom());
        else if (r < 85) send_op(OP_FIND, k, $urandom());
        else if (r < 90) send_op(OP_FIND, $urandom(), $urandom());
        else if (r < 94) send_op($urandom_range(1) ? OP_ADD : OP_FIND, 32'h0, $urandom());
        else if (r < 97) send_op(OP_NOP, $urandom(), $urandom());
        else send_op(OP_CLEAR, $urandom(), $urandom());
        sent++;
        // hold the sender until the pipeline drains
        if (phase == 3 && j == 50) wait_idle();
      end
      phase++;
    end
  endtask

  initial begin
    shadow_init_sel = '0;
    for (int i = 0; i < DEPTH; i++) map_val[i] = '0;
    wipe_map();
    sender_steady = 1'b0;
    sink_steady = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_ops();
    test_capacity_refusal();
    test_random_traffic(1250);

    wait_idle();
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
